// ----- design/bsl_pkg.sv -----
package bsl_pkg;

    localparam int OFFSET_WIDTH = 32;
    localparam int LINE_WIDTH   = 20;
    localparam int NUM_KW       = 23;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_CH1, M_CH2, M_CH3, M_COMMENT,
        M_EQ, M_LT, M_GT, M_BANG, M_AMP, M_BAR, M_SLASH
    } t_mode;

    localparam logic [4:0] K_UNKNOWN = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_NUMBER  = 5'd2;
    localparam logic [4:0] K_CHAR    = 5'd3;
    localparam logic [4:0] K_COMMENT = 5'd4;
    localparam logic [4:0] K_ASSIGN  = 5'd5;
    localparam logic [4:0] K_REL     = 5'd6;
    localparam logic [4:0] K_LOGIC   = 5'd7;
    localparam logic [4:0] K_SHL     = 5'd8;
    localparam logic [4:0] K_SHR     = 5'd9;
    localparam logic [4:0] K_PLUS    = 5'd10;
    localparam logic [4:0] K_MINUS   = 5'd11;
    localparam logic [4:0] K_MULDIV  = 5'd12;
    localparam logic [4:0] K_PUNCT   = 5'd13;
    localparam logic [4:0] K_LBRACK  = 5'd14;
    localparam logic [4:0] K_RBRACK  = 5'd15;
    localparam logic [4:0] K_LBRACE  = 5'd16;
    localparam logic [4:0] K_RBRACE  = 5'd17;
    localparam logic [4:0] K_LPAREN  = 5'd18;
    localparam logic [4:0] K_RPAREN  = 5'd19;
    localparam logic [4:0] K_KEYWORD = 5'd20;
    localparam logic [4:0] K_END     = 5'd21;

    localparam logic [7:0] MAX_ID_RESET = 8'd79;

    typedef struct packed {
        logic [4:0]              kind;
        logic [4:0]              kw;
        logic [OFFSET_WIDTH-1:0] start;
        logic [7:0]              len;
        logic [LINE_WIDTH-1:0]   line;
    } t_tok;

    typedef struct packed {
        logic [2:0] valid;
        t_tok [2:0] tok;
    } t_bundle;

    localparam int TDATA_BITS = 5 + 5 + OFFSET_WIDTH + 8 + LINE_WIDTH;
    localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;

    // keyword text, up to 7 chars, char 0 in low byte
    function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [2:0] p);
        logic [55:0] s;
        unique case (k)
            5'd0:  s = {8'h0, 8'h0, 8'h0, "iota"};
            5'd1:  s = {8'h0, 8'h0, 8'h0, "loob"};
            5'd2:  s = {8'h0, 8'h0, "ssalc"};
            5'd3:  s = {8'h0, 8'h0, 8'h0, "rahc"};
            5'd4:  s = {8'h0, 8'h0, 8'h0, 8'h0, "nic"};
            5'd5:  s = {8'h0, 8'h0, 8'h0, "tuoc"};
            5'd6:  s = {8'h0, 8'h0, 8'h0, "esle"};
            5'd7:  s = {8'h0, 8'h0, "eslaf"};
            5'd8:  s = {8'h0, 8'h0, 8'h0, 8'h0, 8'h0, "fi"};
            5'd9:  s = {8'h0, 8'h0, 8'h0, 8'h0, "tni"};
            5'd10: s = {8'h0, 8'h0, 8'h0, "aoti"};
            5'd11: s = {8'h0, 8'h0, 8'h0, "niam"};
            5'd12: s = {8'h0, 8'h0, 8'h0, 8'h0, "wen"};
            5'd13: s = {8'h0, 8'h0, 8'h0, "llun"};
            5'd14: s = {8'h0, "tcejbo"};
            5'd15: s = {8'h0, "cilbup"};
            5'd16: s = "etavirp";
            5'd17: s = {8'h0, "nruter"};
            5'd18: s = {8'h0, "gnirts"};
            5'd19: s = {8'h0, 8'h0, 8'h0, "siht"};
            5'd20: s = {8'h0, 8'h0, 8'h0, "eurt"};
            5'd21: s = {8'h0, 8'h0, 8'h0, "diov"};
            5'd22: s = {8'h0, 8'h0, "elihw"};
            default: s = '0;
        endcase
        return s[{p, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] kw_len(input logic [4:0] k);
        unique case (k)
            5'd2, 5'd7, 5'd22:                 return 8'd5;
            5'd4, 5'd9, 5'd12:                 return 8'd3;
            5'd8:                              return 8'd2;
            5'd14, 5'd15, 5'd17, 5'd18:        return 8'd6;
            5'd16:                             return 8'd7;
            default:                           return 8'd4;
        endcase
    endfunction

endpackage

// ----- design/bsl_scan.sv -----
module bsl_scan import bsl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_byte,
    input  logic                    i_eoi,
    input  logic [7:0]              i_max_id,
    output t_bundle                 o_res
);
    t_mode                   r_mode, n_mode;
    logic [1:0]              r_flags, n_flags;
    logic [NUM_KW-1:0]       r_cand, n_cand;
    logic [7:0]              r_len, n_len;
    logic [OFFSET_WIDTH-1:0] r_start, n_start;
    logic [OFFSET_WIDTH-1:0] r_pos;
    logic [LINE_WIDTH-1:0]   r_line, n_line;
    logic [7:0]              r_held, n_held;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic logic is_space(input logic [7:0] b);
        return b == " " || b == 8'h0d || b == 8'h0a || b == 8'h09 || b == 8'h00;
    endfunction
    function automatic logic is_symbol(input logic [7:0] b);
        return b == "=" || b == "&" || b == "|" || b == "!" || b == "<" || b == ">"
            || b == "+" || b == "-" || b == "*" || b == "/" || b == "," || b == ";"
            || b == "." || b == "[" || b == "]" || b == "{" || b == "}" || b == "("
            || b == ")";
    endfunction
    function automatic logic is_escape(input logic [7:0] b);
        return b == "a" || b == "b" || b == "t" || b == "n" || b == "v" || b == "f"
            || b == "r" || b == "e" || b == "0";
    endfunction

    t_tok        tk [3];
    logic [2:0]  tv;
    logic        taken;
    logic [LINE_WIDTH-1:0] line_q;
    logic        kw_hit;
    logic [4:0]  kw_idx;
    logic [7:0]  p;
    logic        ok;

    always_comb begin
        n_mode  = r_mode;
        n_flags = r_flags;
        n_cand  = r_cand;
        n_len   = r_len;
        n_start = r_start;
        n_line  = r_line;
        n_held  = r_held;
        for (int i = 0; i < 3; i++) tk[i] = '0;
        tv = '0;
        taken = 1'b0;
        kw_hit = 1'b0;
        kw_idx = '0;
        p = '0;
        ok = 1'b0;
        line_q = r_line;

        // tokens closing a word use the old candidate set
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (r_cand[k] && kw_len(5'(k)) == r_len) begin
                kw_hit = 1'b1;
                kw_idx = 5'(k);
            end
        end

        if (r_mode != M_IDLE) begin
            n_mode = M_IDLE;
            unique case (r_mode)
                M_WORD: begin
                    if (!is_space(i_byte) && !is_symbol(i_byte)) begin
                        n_mode = M_WORD;
                        taken = 1'b1;
                    end else begin
                        tv[0] = 1'b1;
                        tk[0].len = r_len;
                        if (kw_hit) begin
                            tk[0].kind = K_KEYWORD; tk[0].kw = kw_idx;
                        end else if (!r_flags[0]) tk[0].kind = K_NUMBER;
                        else if (!r_flags[1]) tk[0].kind = K_IDENT;
                        else tk[0].kind = K_UNKNOWN;
                    end
                end
                M_CH1: begin
                    if (i_byte == 8'h0a) begin
                        tv[0] = 1'b1; tk[0].kind = K_UNKNOWN; tk[0].len = 8'd1;
                    end else begin
                        n_held = i_byte; n_len = 8'd2; n_mode = M_CH2; taken = 1'b1;
                    end
                end
                M_CH2: begin
                    if (i_byte == "'") begin
                        tv[0] = 1'b1; tk[0].len = 8'd3; taken = 1'b1;
                        tk[0].kind = (r_held >= 8'h20 && r_held <= 8'h7e) ? K_CHAR : K_UNKNOWN;
                    end else if (r_held == "\\" && is_escape(i_byte)) begin
                        n_len = 8'd3; n_mode = M_CH3; taken = 1'b1;
                    end else begin
                        tv[0] = 1'b1; tk[0].kind = K_UNKNOWN; tk[0].len = 8'd2;
                    end
                end
                M_CH3: begin
                    tv[0] = 1'b1;
                    if (i_byte == "'") begin
                        tk[0].kind = K_CHAR; tk[0].len = 8'd4; taken = 1'b1;
                    end else begin
                        tk[0].kind = K_UNKNOWN; tk[0].len = 8'd3;
                    end
                end
                M_COMMENT: begin
                    taken = 1'b1;
                    if (i_byte == 8'h0a) begin
                        tv[0] = 1'b1; tk[0].kind = K_COMMENT; tk[0].len = r_len;
                        if (r_line != '1) n_line = r_line + 1'b1;
                    end else begin
                        if (r_len != 8'hff) n_len = r_len + 8'd1;
                        n_mode = M_COMMENT;
                    end
                end
                M_EQ: begin
                    tv[0] = 1'b1;
                    if (i_byte == "=") begin
                        tk[0].kind = K_REL; tk[0].len = 8'd2; taken = 1'b1;
                    end else begin
                        tk[0].kind = K_ASSIGN; tk[0].len = 8'd1;
                    end
                end
                M_LT, M_GT: begin
                    tv[0] = 1'b1; tk[0].len = 8'd2; taken = 1'b1;
                    if (i_byte == "=") tk[0].kind = K_REL;
                    else if (r_mode == M_LT && i_byte == "<") tk[0].kind = K_SHL;
                    else if (r_mode == M_GT && i_byte == ">") tk[0].kind = K_SHR;
                    else begin
                        tk[0].kind = K_REL; tk[0].len = 8'd1; taken = 1'b0;
                    end
                end
                M_BANG, M_AMP, M_BAR: begin
                    tv[0] = 1'b1;
                    if ((r_mode == M_BANG && i_byte == "=")
                        || (r_mode == M_AMP && i_byte == "&")
                        || (r_mode == M_BAR && i_byte == "|")) begin
                        tk[0].kind = (r_mode == M_BANG) ? K_REL : K_LOGIC;
                        tk[0].len = 8'd2; taken = 1'b1;
                    end else begin
                        tk[0].kind = K_UNKNOWN; tk[0].len = 8'd1;
                    end
                end
                M_SLASH: begin
                    if (i_byte == "/") begin
                        n_len = 8'd2; n_mode = M_COMMENT; taken = 1'b1;
                    end else begin
                        tv[0] = 1'b1; tk[0].kind = K_MULDIV; tk[0].len = 8'd1;
                    end
                end
                default: ;
            endcase
            tk[0].start = r_start;
            tk[0].line  = r_line;
        end
        line_q = n_line;

        // fresh scan of the byte when the pending token did not take it
        if (!taken) begin
            tk[1].start = r_pos;
            tk[1].len   = 8'd1;
            tk[1].line  = line_q;
            unique case (i_byte)
                8'h0a: if (line_q != '1) n_line = line_q + 1'b1;
                " ", 8'h0d, 8'h09, 8'h00: ;
                "+": begin tv[1] = 1'b1; tk[1].kind = K_PLUS; end
                "-": begin tv[1] = 1'b1; tk[1].kind = K_MINUS; end
                "*": begin tv[1] = 1'b1; tk[1].kind = K_MULDIV; end
                ",", ";", ".": begin tv[1] = 1'b1; tk[1].kind = K_PUNCT; end
                "[": begin tv[1] = 1'b1; tk[1].kind = K_LBRACK; end
                "]": begin tv[1] = 1'b1; tk[1].kind = K_RBRACK; end
                "{": begin tv[1] = 1'b1; tk[1].kind = K_LBRACE; end
                "}": begin tv[1] = 1'b1; tk[1].kind = K_RBRACE; end
                "(": begin tv[1] = 1'b1; tk[1].kind = K_LPAREN; end
                ")": begin tv[1] = 1'b1; tk[1].kind = K_RPAREN; end
                "=": begin n_mode = M_EQ; n_start = r_pos; n_len = 8'd1; end
                "<": begin n_mode = M_LT; n_start = r_pos; n_len = 8'd1; end
                ">": begin n_mode = M_GT; n_start = r_pos; n_len = 8'd1; end
                "!": begin n_mode = M_BANG; n_start = r_pos; n_len = 8'd1; end
                "&": begin n_mode = M_AMP; n_start = r_pos; n_len = 8'd1; end
                "|": begin n_mode = M_BAR; n_start = r_pos; n_len = 8'd1; end
                "/": begin n_mode = M_SLASH; n_start = r_pos; n_len = 8'd1; end
                "'": begin n_mode = M_CH1; n_start = r_pos; n_len = 8'd1; end
                default: begin
                    n_mode = M_WORD; n_start = r_pos; n_len = 8'd0;
                    n_flags = 2'b00; n_cand = '1;
                end
            endcase
        end

        // extend a word with this byte (new or continuing)
        if (n_mode == M_WORD) begin
            p = n_len;
            for (int k = 0; k < NUM_KW; k++) begin
                if (p >= kw_len(5'(k)) || kw_char(5'(k), p[2:0]) != i_byte) n_cand[k] = 1'b0;
            end
            if (!is_digit(i_byte)) n_flags[0] = 1'b1;
            ok = (p == 8'd0) ? is_letter(i_byte)
                : (is_letter(i_byte) || is_digit(i_byte) || i_byte == "_");
            if (!ok || p == 8'hff) n_flags[1] = 1'b1;
            if (p != 8'hff) p = p + 8'd1;
            n_len = p;
            if (p > i_max_id) n_flags[1] = 1'b1;
        end

        // end of input: flush then end token, then back to reset
        if (i_eoi) begin
            tk[2].start = r_pos + 1'b1;
            tk[2].line  = n_line;
            tk[2].kind  = K_END;
            if (n_mode != M_IDLE) begin
                tk[1].start = n_start;
                tk[1].line  = n_line;
                tk[1].len   = n_len;
                tk[1].kw    = '0;
                tv[1] = 1'b1;
                unique case (n_mode)
                    M_WORD: begin
                        kw_hit = 1'b0;
                        for (int k = NUM_KW - 1; k >= 0; k--) begin
                            if (n_cand[k] && kw_len(5'(k)) == n_len) begin
                                kw_hit = 1'b1; kw_idx = 5'(k);
                            end
                        end
                        if (kw_hit) begin
                            tk[1].kind = K_KEYWORD; tk[1].kw = kw_idx;
                        end else if (!n_flags[0]) tk[1].kind = K_NUMBER;
                        else if (!n_flags[1]) tk[1].kind = K_IDENT;
                        else tk[1].kind = K_UNKNOWN;
                    end
                    M_COMMENT: tk[1].kind = K_COMMENT;
                    M_EQ: tk[1].kind = K_ASSIGN;
                    M_LT, M_GT: tk[1].kind = K_REL;
                    M_SLASH: tk[1].kind = K_MULDIV;
                    default: tk[1].kind = K_UNKNOWN;
                endcase
            end
            tv[2] = 1'b1;
        end

        o_res.valid = tv;
        for (int i = 0; i < 3; i++) o_res.tok[i] = tk[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_flags <= '0; r_cand <= '1; r_len <= '0;
            r_start <= '0; r_pos <= '0; r_line <= LINE_WIDTH'(1); r_held <= '0;
        end else if (i_step) begin
            if (i_eoi) begin
                r_mode <= M_IDLE; r_flags <= '0; r_cand <= '1; r_len <= '0;
                r_start <= '0; r_pos <= '0; r_line <= LINE_WIDTH'(1); r_held <= '0;
            end else begin
                r_mode <= n_mode; r_flags <= n_flags; r_cand <= n_cand; r_len <= n_len;
                r_start <= n_start; r_pos <= r_pos + 1'b1; r_line <= n_line;
                r_held <= n_held;
            end
        end
    end

endmodule

// ----- design/bsl_out.sv -----
module bsl_out import bsl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_bundle            i_res,
    output logic               o_free,
    input  logic               i_tready,
    output logic               o_tvalid,
    output logic [TDATA_W-1:0] o_tdata,
    output logic               o_tlast
);
    // holds up to three tokens of one byte and plays them out in order
    logic [2:0] r_valid;
    t_tok [2:0] r_tok;
    logic [1:0] sel;
    logic [2:0] rest;

    always_comb begin
        sel = 2'd0;
        if (r_valid[2]) sel = 2'd2;
        if (r_valid[1]) sel = 2'd1;
        if (r_valid[0]) sel = 2'd0;
        rest = r_valid;
        rest[sel] = 1'b0;
    end

    assign o_tvalid = |r_valid;
    assign o_tlast  = o_tvalid && (rest == 3'b000);
    assign o_tdata  = TDATA_W'({r_tok[sel].line, r_tok[sel].len, r_tok[sel].start,
                                r_tok[sel].kw, r_tok[sel].kind});
    assign o_free   = !o_tvalid || (i_tready && o_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (o_tvalid && i_tready) begin
            r_valid <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_tok <= i_res.tok;
    end

endmodule

// ----- design/byte_stream_lexer.sv -----
// channel  | signals                          | contents
// s_axis   | s_axis_tvalid/tready/tdata/tlast | tdata = source byte, tlast = end of input
// m_axis   | m_axis_tvalid/tready/tdata/tlast | tdata = one token, tlast = last of byte
// config   | i_cfg_we, i_cfg_wdata            | max identifier length (reset 79)
// one byte per cycle when each byte yields at most one token and m_axis is ready; a byte that
// yields more tokens holds the output register until the last of them is taken
// bytes are scanned combinationally into a three-token result register
// reset is synchronous and active low, no clearing pass
// a stalled m_axis holds s_axis_tready low once the result register is full
module byte_stream_lexer import bsl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // input_byte
    input  logic               s_axis_tlast,  // end_of_input
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // token_kind, keyword_index, token_start, token_length, line_number
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast   // last_of_run
);
    logic [7:0] r_max_id;
    t_bundle    res;
    logic       step, free;

    assign s_axis_tready = free;
    assign step = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_id <= MAX_ID_RESET;
        else if (i_cfg_we) r_max_id <= i_cfg_wdata;
    end

    bsl_scan u_scan (
        .i_clk, .i_rst_n, .i_step(step), .i_byte(s_axis_tdata), .i_eoi(s_axis_tlast),
        .i_max_id(r_max_id), .o_res(res)
    );

    bsl_out u_out (
        .i_clk, .i_rst_n, .i_load(step), .i_res(res), .o_free(free),
        .i_tready(m_axis_tready), .o_tvalid(m_axis_tvalid), .o_tdata(m_axis_tdata),
        .o_tlast(m_axis_tlast)
    );

endmodule

// ----- design/bsl_check.sv -----
module bsl_check import bsl_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               s_axis_tlast,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped while stalled");
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4:0] == K_END |-> m_axis_tlast)
        else $error("end token not last");
    a_eoi_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
        else $error("end of input gave no token");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

bind byte_stream_lexer bsl_check u_bsl_check (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

// ----- verif/tb_lexer_checker.sv -----
module tb_lexer_checker import bsl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,
    input  logic               s_axis_tlast,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,
    input  logic               m_axis_tlast,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [4:0]              kind;
        logic [4:0]              kw;
        logic [OFFSET_WIDTH-1:0] start;
        logic [7:0]              len;
        logic [LINE_WIDTH-1:0]   line;
        logic                    last;
    } t_token_exp;

    t_token_exp token_queue[$];
    t_token_exp run_tokens[$];

    logic [7:0]              id_limit;
    t_mode                   mode;
    logic [1:0]              flags;
    logic [NUM_KW-1:0]       kw_cand;
    logic [7:0]              cur_len;
    logic [OFFSET_WIDTH-1:0] cur_start;
    logic [OFFSET_WIDTH-1:0] position;
    logic [LINE_WIDTH-1:0]   line_cnt;
    logic [7:0]              held;
    int                      fails;

    assign o_fail_count = fails;
    assign o_pending    = token_queue.size();

    function automatic string kw_string(int k);
        string names[NUM_KW] = '{"atoi", "bool", "class", "char", "cin", "cout", "else",
            "false", "if", "int", "itoa", "main", "new", "null", "object", "public",
            "private", "return", "string", "this", "true", "void", "while"};
        return names[k];
    endfunction

    function automatic bit letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit blank(logic [7:0] b);
        return b == " " || b == 8'h0d || b == 8'h0a || b == 8'h09 || b == 8'h00;
    endfunction

    function automatic bit symbol(logic [7:0] b);
        case (b)
            "=", "&", "|", "!", "<", ">", "+", "-", "*", "/", ",", ";", ".",
            "[", "]", "{", "}", "(", ")": return 1;
            default: return 0;
        endcase
    endfunction

    function automatic bit escape_char(logic [7:0] b);
        case (b)
            "a", "b", "t", "n", "v", "f", "r", "e", "0": return 1;
            default: return 0;
        endcase
    endfunction

    function automatic void push_token(logic [4:0] kind, logic [4:0] kw,
                                       logic [OFFSET_WIDTH-1:0] start, logic [7:0] len);
        t_token_exp t;
        t.kind = kind; t.kw = kw; t.start = start; t.len = len;
        t.line = line_cnt; t.last = 0;
        run_tokens.push_back(t);
    endfunction

    function automatic void bump_line();
        if (line_cnt != '1) line_cnt++;
    endfunction

    task automatic clear_scan();
        mode = M_IDLE; flags = 0; kw_cand = '1; cur_len = 0;
        cur_start = 0; position = 0; line_cnt = 1; held = 0;
    endtask

    function automatic void grow_word(logic [7:0] b);
        int p;
        string s;
        bit ok;
        p = cur_len;
        for (int k = 0; k < NUM_KW; k++) begin
            s = kw_string(k);
            if (kw_cand[k] && (p >= s.len() || s[p] != b)) kw_cand[k] = 0;
        end
        if (!digit(b)) flags[0] = 1;
        ok = (p == 0) ? letter(b) : (letter(b) || digit(b) || b == "_");
        if (!ok || p >= 255) flags[1] = 1;
        if (p < 255) p++;
        cur_len = 8'(p);
        if (p > id_limit) flags[1] = 1;
    endfunction

    function automatic void close_word();
        for (int k = 0; k < NUM_KW; k++) begin
            if (kw_cand[k] && kw_string(k).len() == cur_len) begin
                push_token(K_KEYWORD, 5'(k), cur_start, cur_len);
                return;
            end
        end
        if (!flags[0]) push_token(K_NUMBER, 0, cur_start, cur_len);
        else if (!flags[1]) push_token(K_IDENT, 0, cur_start, cur_len);
        else push_token(K_UNKNOWN, 0, cur_start, cur_len);
    endfunction

    task automatic scan_fresh(logic [7:0] b, logic [OFFSET_WIDTH-1:0] pos);
        t_mode m;
        case (b)
            8'h0a: begin bump_line(); return; end
            " ", 8'h0d, 8'h09, 8'h00: return;
            "+": begin push_token(K_PLUS, 0, pos, 1); return; end
            "-": begin push_token(K_MINUS, 0, pos, 1); return; end
            "*": begin push_token(K_MULDIV, 0, pos, 1); return; end
            ",", ";", ".": begin push_token(K_PUNCT, 0, pos, 1); return; end
            "[": begin push_token(K_LBRACK, 0, pos, 1); return; end
            "]": begin push_token(K_RBRACK, 0, pos, 1); return; end
            "{": begin push_token(K_LBRACE, 0, pos, 1); return; end
            "}": begin push_token(K_RBRACE, 0, pos, 1); return; end
            "(": begin push_token(K_LPAREN, 0, pos, 1); return; end
            ")": begin push_token(K_RPAREN, 0, pos, 1); return; end
            "=": m = M_EQ;
            "<": m = M_LT;
            ">": m = M_GT;
            "!": m = M_BANG;
            "&": m = M_AMP;
            "|": m = M_BAR;
            "/": m = M_SLASH;
            "'": m = M_CH1;
            default: m = M_WORD;
        endcase
        cur_start = pos;
        cur_len = 1;
        mode = m;
        if (m == M_WORD) begin
            cur_len = 0; flags = 0; kw_cand = '1;
            grow_word(b);
        end
    endtask

    // returns 1 when the byte extends the pending token
    function automatic bit scan_pending(logic [7:0] b);
        logic [OFFSET_WIDTH-1:0] s;
        t_mode m;
        s = cur_start;
        m = mode;
        mode = M_IDLE;
        case (m)
            M_WORD: begin
                if (!blank(b) && !symbol(b)) begin
                    mode = M_WORD; grow_word(b); return 1;
                end
                close_word();
                return 0;
            end
            M_CH1: begin
                if (b == 8'h0a) begin push_token(K_UNKNOWN, 0, s, 1); return 0; end
                held = b; cur_len = 2; mode = M_CH2;
                return 1;
            end
            M_CH2: begin
                if (b == "'") begin
                    push_token((held >= 8'h20 && held <= 8'h7e) ? K_CHAR : K_UNKNOWN,
                               0, s, 3);
                    return 1;
                end
                if (held == "\\" && escape_char(b)) begin
                    cur_len = 3; mode = M_CH3; return 1;
                end
                push_token(K_UNKNOWN, 0, s, 2);
                return 0;
            end
            M_CH3: begin
                if (b == "'") begin push_token(K_CHAR, 0, s, 4); return 1; end
                push_token(K_UNKNOWN, 0, s, 3);
                return 0;
            end
            M_COMMENT: begin
                if (b == 8'h0a) begin
                    push_token(K_COMMENT, 0, s, cur_len); bump_line(); return 1;
                end
                if (cur_len != 8'hff) cur_len++;
                mode = M_COMMENT;
                return 1;
            end
            M_EQ: begin
                if (b == "=") begin push_token(K_REL, 0, s, 2); return 1; end
                push_token(K_ASSIGN, 0, s, 1);
                return 0;
            end
            M_LT, M_GT: begin
                if (b == "=") begin push_token(K_REL, 0, s, 2); return 1; end
                if (m == M_LT && b == "<") begin push_token(K_SHL, 0, s, 2); return 1; end
                if (m == M_GT && b == ">") begin push_token(K_SHR, 0, s, 2); return 1; end
                push_token(K_REL, 0, s, 1);
                return 0;
            end
            M_BANG: begin
                if (b == "=") begin push_token(K_REL, 0, s, 2); return 1; end
                push_token(K_UNKNOWN, 0, s, 1);
                return 0;
            end
            M_AMP, M_BAR: begin
                if (b == (m == M_AMP ? "&" : "|")) begin
                    push_token(K_LOGIC, 0, s, 2); return 1;
                end
                push_token(K_UNKNOWN, 0, s, 1);
                return 0;
            end
            M_SLASH: begin
                if (b == "/") begin cur_len = 2; mode = M_COMMENT; return 1; end
                push_token(K_MULDIV, 0, s, 1);
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    task automatic flush_pending();
        case (mode)
            M_WORD: close_word();
            M_CH1: push_token(K_UNKNOWN, 0, cur_start, 1);
            M_CH2: push_token(K_UNKNOWN, 0, cur_start, 2);
            M_CH3: push_token(K_UNKNOWN, 0, cur_start, 3);
            M_COMMENT: push_token(K_COMMENT, 0, cur_start, cur_len);
            M_EQ: push_token(K_ASSIGN, 0, cur_start, 1);
            M_LT, M_GT: push_token(K_REL, 0, cur_start, 1);
            M_BANG, M_AMP, M_BAR: push_token(K_UNKNOWN, 0, cur_start, 1);
            M_SLASH: push_token(K_MULDIV, 0, cur_start, 1);
            default: ;
        endcase
        mode = M_IDLE;
    endtask

    task automatic lex_byte(logic [7:0] b, logic eoi);
        bit taken;
        logic [OFFSET_WIDTH-1:0] pos;
        pos = position;
        taken = 0;
        run_tokens.delete();
        if (mode != M_IDLE) taken = scan_pending(b);
        if (!taken) scan_fresh(b, pos);
        if (eoi) begin
            flush_pending();
            push_token(K_END, 0, pos + 1, 0);
            clear_scan();
        end else begin
            position = pos + 1;
        end
        if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last = 1;
        foreach (run_tokens[i]) token_queue.push_back(run_tokens[i]);
    endtask

    always @(posedge i_clk) begin
        t_token_exp e;
        t_tok got;
        if (!i_rst_n) begin
            id_limit = MAX_ID_RESET;
            clear_scan();
            token_queue.delete();
            fails = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                // fields packed from the lowest bit up
                got.kind  = m_axis_tdata[4:0];
                got.kw    = m_axis_tdata[9:5];
                got.start = m_axis_tdata[10 +: OFFSET_WIDTH];
                got.len   = m_axis_tdata[10 + OFFSET_WIDTH +: 8];
                got.line  = m_axis_tdata[18 + OFFSET_WIDTH +: LINE_WIDTH];
                if (token_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected word kind=%0d start=%0d len=%0d",
                                 got.kind, got.start, got.len);
                end else begin
                    e = token_queue.pop_front();
                    if (got.kind !== e.kind || got.kw !== e.kw || got.start !== e.start ||
                        got.len !== e.len || got.line !== e.line ||
                        m_axis_tlast !== e.last) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch exp k=%0d kw=%0d s=%0d l=%0d ln=%0d t=%0b %s",
                                     e.kind, e.kw, e.start, e.len, e.line, e.last,
                                     $sformatf("got k=%0d kw=%0d s=%0d l=%0d ln=%0d t=%0b",
                                     got.kind, got.kw, got.start, got.len, got.line,
                                     m_axis_tlast));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) lex_byte(s_axis_tdata, s_axis_tlast);
            if (i_cfg_we) id_limit = i_cfg_wdata;
        end
    end
endmodule

// ----- verif/tb_top.sv -----
module tb_top import bsl_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [7:0]         i_cfg_wdata = 0;
    logic               s_axis_tvalid = 0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 0;
    logic               s_axis_tlast = 0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    int                 fail_count;
    int                 pending;
    bit                 calm = 0;
    int                 idle_cycles = 0;
    byte unsigned       src[$];
    bit                 src_eoi[$];

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    byte_stream_lexer dut (.*);

    tb_lexer_checker chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    // receiver stalls in random bursts
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 5);
                m_axis_tready <= 0;
                repeat (n) @(negedge i_clk);
            end
            m_axis_tready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic add_text(string s, bit eoi_at_end);
        for (int i = 0; i < s.len(); i++) begin
            src.push_back(s[i]);
            src_eoi.push_back(eoi_at_end && i == s.len() - 1);
        end
    endtask

    task automatic send_all();
        int n;
        while (src.size() > 0) begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 5);
                s_axis_tvalid <= 0;
                repeat (n) @(negedge i_clk);
            end
            s_axis_tvalid <= 1;
            s_axis_tdata  <= src.pop_front();
            s_axis_tlast  <= src_eoi.pop_front();
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 0;
    endtask

    task automatic drain_and_write(logic [7:0] v);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 0;
    endtask

    function automatic string random_token(int lim);
        string kws[8] = '{"while", "private", "atoi", "if", "int", "return", "this", "null"};
        string ops[10] = '{"==", "!=", "<=", ">=", "<<", ">>", "&&", "||", "=", "/"};
        string esc = "abtnvfre0";
        string syms = "+-*,;.[]{}()!&|<>";
        string s;
        int n;
        s = "";
        case ($urandom_range(0, 9))
            0: s = kws[$urandom_range(0, 7)];
            1: s = ops[$urandom_range(0, 9)];
            2: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(48, 57)))};
            end
            3: begin
                s = "a";
                n = $urandom_range(0, lim);
                for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(97, 122)))};
                if ($urandom_range(0, 1)) s = {s, "_9"};
            end
            4: s = {"'", string'(byte'($urandom_range(32, 126))), "'"};
            5: s = {"'\\", string'(esc[$urandom_range(0, 8)]), "'"};
            6: s = "// note x\n";
            7: s = string'(syms[$urandom_range(0, 16)]);
            8: s = string'(byte'($urandom_range(0, 255)));
            default: s = "\n";
        endcase
        if ($urandom_range(0, 2) != 0) s = {s, " "};
        return s;
    endfunction

    initial begin
        string s;
        int limits[4] = '{1, 255, 3, 0};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed: operators, keywords, literals, comments, lone symbols
        add_text("while x1_a=0==1!=<=>=<<>>&&||<>!&|+-*/,;.[]{}()", 0);
        add_text("\n'a''\\n''\\q'' '\n'\xff\x80 12 // c\n9a ", 1);
        send_all();
        foreach (limits[i]) begin
            drain_and_write(8'(limits[i]));
            add_text("ab abcd y_7 ", 0);
            for (int k = 0; k < 8; k++) begin
                s = random_token(6);
                add_text(s, k == 7);
            end
            if (i == 3) calm = 1;
            send_all();
        end
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
design/bsl_pkg.sv
design/bsl_scan.sv
design/bsl_out.sv
design/byte_stream_lexer.sv
design/bsl_check.sv
verif/tb_lexer_checker.sv
verif/tb_top.sv
